// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file of the bit-timing receiver.
// Expects clk_i and rst_ni to be visible where the macros are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define CBTR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define CBTR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/cbtr_pkg.sv =====
// Package for the CEC bit-timing receiver: tick thresholds, drop codes and
// the structs passed between the receiver modules. No dependencies.
`timescale 1ns / 1ps

package cbtr_pkg;

  localparam int unsigned MaxBlocksDefault = 16;

  localparam logic [15:0] StartLowMin = 16'd114;
  localparam logic [15:0] StartLowMax = 16'd127;
  localparam logic [16:0] StartPerMin = 17'd140;
  localparam logic [16:0] StartPerMax = 17'd154;
  localparam logic [15:0] OneLowMin   = 16'd13;
  localparam logic [15:0] OneLowMax   = 16'd26;
  localparam logic [15:0] ZeroLowMin  = 16'd42;
  localparam logic [15:0] ZeroLowMax  = 16'd55;
  localparam logic [16:0] BitPerMin   = 17'd67;
  localparam logic [16:0] BitPerMax   = 17'd90;
  localparam logic [3:0]  BcastAddr   = 4'hf;

  localparam logic [2:0] DROP_NONE       = 3'd0;
  localparam logic [2:0] DROP_START_LOW  = 3'd1;
  localparam logic [2:0] DROP_START_PER  = 3'd2;
  localparam logic [2:0] DROP_DATA_LOW   = 3'd3;
  localparam logic [2:0] DROP_DATA_PER   = 3'd4;
  localparam logic [2:0] DROP_NOT_ADDR   = 3'd5;
  localparam logic [2:0] DROP_TOO_LONG   = 3'd6;

  localparam logic REG_OWN_ADDRESS    = 1'b0;
  localparam logic REG_RECEIVE_ENABLE = 1'b1;

  typedef struct packed {
    logic [3:0] own_address;
    logic       receive_enable;
  } cfg_t;

  typedef struct packed {
    logic start_low_ok;
    logic start_per_ok;
    logic one_low;
    logic zero_low;
    logic bit_per_ok;
  } timing_t;

  typedef struct packed {
    logic       next_edge_rising;
    logic [2:0] drop_reason;
    logic       message_done;
    logic       send_ack;
    logic       is_broadcast;
    logic [3:0] byte_index;
    logic [7:0] byte_value;
    logic       byte_valid;
  } res_t;

endpackage

// ===== rtl/core/cbtr_apb_regs.sv =====
// APB register file of the CEC bit-timing receiver: own address and enable.
// Depends on cbtr_pkg.
`timescale 1ns / 1ps

module cbtr_apb_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cbtr_pkg::cfg_t     cfg_o
);
  import cbtr_pkg::*;

  logic [3:0] own_address_q;
  logic       receive_enable_q;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_address_q    <= 4'd0;
      receive_enable_q <= 1'b0;
    end else if (wr_en) begin
      case (paddr[2])
        REG_OWN_ADDRESS:    own_address_q    <= pwdata[3:0];
        REG_RECEIVE_ENABLE: receive_enable_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_OWN_ADDRESS:    prdata = {28'd0, own_address_q};
      REG_RECEIVE_ENABLE: prdata = {31'd0, receive_enable_q};
      default:            prdata = 32'd0;
    endcase
  end

  assign cfg_o.own_address    = own_address_q;
  assign cfg_o.receive_enable = receive_enable_q;

endmodule

// ===== rtl/core/cbtr_bit_classifier.sv =====
// Interval classifier: compares low time and bit period against the start
// and data bit windows. Depends on cbtr_pkg.
`timescale 1ns / 1ps

module cbtr_bit_classifier (
  input  logic [15:0]          interval_i,
  input  logic [15:0]          saved_low_i,
  output cbtr_pkg::timing_t    timing_o
);
  import cbtr_pkg::*;

  logic [16:0] period;

  assign period = {1'b0, saved_low_i} + {1'b0, interval_i};

  assign timing_o.start_low_ok = (interval_i >= StartLowMin) && (interval_i <= StartLowMax);
  assign timing_o.start_per_ok = (period >= StartPerMin) && (period <= StartPerMax);
  assign timing_o.one_low      = (interval_i >= OneLowMin) && (interval_i <= OneLowMax);
  assign timing_o.zero_low     = (interval_i >= ZeroLowMin) && (interval_i <= ZeroLowMax);
  assign timing_o.bit_per_ok   = (period >= BitPerMin) && (period <= BitPerMax);

endmodule

// ===== rtl/core/cbtr_out_skid.sv =====
// Result register with skid stage for the receiver output stream.
// Depends on cbtr_pkg.
`timescale 1ns / 1ps

module cbtr_out_skid (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  cbtr_pkg::res_t     in_res_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output cbtr_pkg::res_t     out_res_o
);
  import cbtr_pkg::*;

  logic out_valid_q;
  logic skid_valid_q;
  res_t out_q;
  res_t skid_q;
  logic take;
  logic push;

  assign in_ready_o  = !skid_valid_q;
  assign take        = out_valid_q && out_ready_i;
  assign push        = in_valid_i && !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push) begin
      if (out_valid_q && !take) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (take) begin
        out_q <= skid_q;
      end
    end else if (push) begin
      if (out_valid_q && !take) begin
        skid_q <= in_res_i;
      end else begin
        out_q <= in_res_i;
      end
    end
  end

endmodule

// ===== rtl/core/cec_bit_timing_receiver_unit.sv =====
// CEC bit-timing receiver top level: bit/block state machine, APB registers,
// interval classifier and output skid stage. Depends on cbtr_pkg and submodules.
//
// Takes one edge interval (ticks of a 32768 Hz timebase) per request and
// returns exactly one result per request. A new interval is accepted every
// cycle while the skid is empty; the whole step (one 17-bit add for the bit
// period and a few window compares) settles between the state registers and
// the result register. A two-entry output stage (result register plus skid)
// takes one more interval under output stall. Byte fields are zero whenever
// tuser (byte_valid) is low. Write configuration only while idle.
`timescale 1ns / 1ps

module cec_bit_timing_receiver_unit #(
  parameter int unsigned MAX_BLOCKS = cbtr_pkg::MaxBlocksDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [15:0] interval
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [7:0] byte_value, [11:8] byte_index, [12] is_broadcast, [13] send_ack,
  // [16:14] drop_reason, [17] next_edge_rising, [23:18] zero
  output logic [23:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o,   // message_done
  output logic        m_axis_tuser_o,   // [0] byte_valid
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import cbtr_pkg::*;

  localparam logic [2:0] PH_IDLE       = 3'd0;
  localparam logic [2:0] PH_START_LOW  = 3'd1;
  localparam logic [2:0] PH_START_HIGH = 3'd2;
  localparam logic [2:0] PH_BIT_LOW    = 3'd3;
  localparam logic [2:0] PH_BIT_HIGH   = 3'd4;

  localparam logic [4:0] MaxBlk = 5'(MAX_BLOCKS);

  cfg_t    cfg;
  timing_t tim;
  res_t    res;
  res_t    res_out;
  logic    accept;

  logic [2:0]  phase_q, phase_d;
  logic [15:0] saved_low_q, saved_low_d;
  logic [3:0]  bit_count_q, bit_count_d;
  logic [3:0]  block_count_q, block_count_d;
  logic [7:0]  shift_q, shift_d;
  logic        last_bit_q, last_bit_d;
  logic        bcast_q, bcast_d;
  logic        cur_bit_q, cur_bit_d;
  logic [7:0]  shift_nx;

  cbtr_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  cbtr_bit_classifier u_class (
    .interval_i  (s_axis_tdata_i),
    .saved_low_i (saved_low_q),
    .timing_o    (tim)
  );

  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign shift_nx = {shift_q[6:0], cur_bit_q};

  always_comb begin
    phase_d       = phase_q;
    saved_low_d   = saved_low_q;
    bit_count_d   = bit_count_q;
    block_count_d = block_count_q;
    shift_d       = shift_q;
    last_bit_d    = last_bit_q;
    bcast_d       = bcast_q;
    cur_bit_d     = cur_bit_q;
    res           = '0;
    case (phase_q)
      PH_START_LOW: begin
        if (tim.start_low_ok) begin
          saved_low_d = s_axis_tdata_i;
          phase_d     = PH_START_HIGH;
        end else begin
          res.drop_reason = DROP_START_LOW;
          phase_d         = PH_IDLE;
        end
      end
      PH_START_HIGH: begin
        res.next_edge_rising = 1'b1;
        if (tim.start_per_ok) begin
          phase_d       = PH_BIT_LOW;
          bit_count_d   = 4'd0;
          block_count_d = 4'd0;
          shift_d       = 8'd0;
          last_bit_d    = 1'b0;
          bcast_d       = 1'b0;
        end else begin
          res.drop_reason = DROP_START_PER;
          phase_d         = PH_START_LOW;
        end
      end
      PH_BIT_LOW: begin
        saved_low_d = s_axis_tdata_i;
        if (tim.one_low) begin
          cur_bit_d = 1'b1;
          phase_d   = PH_BIT_HIGH;
        end else if (tim.zero_low) begin
          cur_bit_d = 1'b0;
          phase_d   = PH_BIT_HIGH;
        end else begin
          res.drop_reason = DROP_DATA_LOW;
          phase_d         = PH_IDLE;
        end
      end
      PH_BIT_HIGH: begin
        if (!tim.bit_per_ok) begin
          res.drop_reason = DROP_DATA_PER;
          phase_d         = PH_IDLE;
        end else if (bit_count_q < 4'd8) begin
          shift_d              = shift_nx;
          bit_count_d          = bit_count_q + 4'd1;
          phase_d              = PH_BIT_LOW;
          res.next_edge_rising = 1'b1;
          if (block_count_q == 4'd0 && bit_count_q == 4'd7) begin
            if (shift_nx[3:0] == BcastAddr) begin
              bcast_d = 1'b1;
            end else if (shift_nx[3:0] != cfg.own_address) begin
              res.drop_reason      = DROP_NOT_ADDR;
              phase_d              = PH_IDLE;
              res.next_edge_rising = 1'b0;
            end
          end
        end else if (bit_count_q == 4'd8) begin
          last_bit_d           = cur_bit_q;
          res.byte_valid       = 1'b1;
          res.byte_value       = shift_q;
          res.byte_index       = block_count_q;
          res.is_broadcast     = bcast_q;
          res.send_ack         = !bcast_q;
          res.message_done     = cur_bit_q;
          bit_count_d          = 4'd9;
          phase_d              = PH_BIT_LOW;
          res.next_edge_rising = 1'b1;
        end else begin
          bit_count_d = 4'd0;
          shift_d     = 8'd0;
          if (last_bit_q) begin
            phase_d = PH_IDLE;
          end else if (({1'b0, block_count_q} + 5'd1) >= MaxBlk) begin
            res.drop_reason = DROP_TOO_LONG;
            phase_d         = PH_IDLE;
          end else begin
            block_count_d        = block_count_q + 4'd1;
            phase_d              = PH_BIT_LOW;
            res.next_edge_rising = 1'b1;
          end
        end
      end
      default: begin
        phase_d = PH_IDLE;
        if (cfg.receive_enable) begin
          phase_d              = PH_START_LOW;
          res.next_edge_rising = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      saved_low_q   <= 16'd0;
      bit_count_q   <= 4'd0;
      block_count_q <= 4'd0;
      shift_q       <= 8'd0;
      last_bit_q    <= 1'b0;
      bcast_q       <= 1'b0;
      cur_bit_q     <= 1'b0;
    end else if (accept) begin
      phase_q       <= phase_d;
      saved_low_q   <= saved_low_d;
      bit_count_q   <= bit_count_d;
      block_count_q <= block_count_d;
      shift_q       <= shift_d;
      last_bit_q    <= last_bit_d;
      bcast_q       <= bcast_d;
      cur_bit_q     <= cur_bit_d;
    end
  end

  cbtr_out_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_res_i    (res),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_res_o   (res_out)
  );

  assign m_axis_tdata_o = {6'd0, res_out.next_edge_rising, res_out.drop_reason,
                           res_out.send_ack, res_out.is_broadcast,
                           res_out.byte_index, res_out.byte_value};
  assign m_axis_tlast_o = res_out.message_done;
  assign m_axis_tuser_o = res_out.byte_valid;

endmodule

// ===== rtl/core/cbtr_checker.sv =====
// Port-level checker for the CEC bit-timing receiver, bound to the top level.
// Depends on cbtr_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cbtr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [23:0] m_axis_tdata_o,
  input logic        m_axis_tlast_o,
  input logic        m_axis_tuser_o,
  input logic        pready
);
  import cbtr_pkg::*;

  `CBTR_ASSERT(a_pready_high, pready, "pready dropped")
  `CBTR_ASSERT(a_out_hold, (m_axis_tvalid_o && !m_axis_tready_i) |=> m_axis_tvalid_o, "result lost under stall")
  `CBTR_ASSERT_IMPL(a_no_byte_zero, m_axis_tvalid_o && !m_axis_tuser_o, m_axis_tdata_o[13:0] == 14'd0 && !m_axis_tlast_o, "byte fields set without byte")
  `CBTR_ASSERT_IMPL(a_drop_range, m_axis_tvalid_o, m_axis_tdata_o[16:14] <= DROP_TOO_LONG, "drop reason out of range")
  `CBTR_ASSERT_IMPL(a_ack_rule, m_axis_tvalid_o, m_axis_tdata_o[13] == (m_axis_tuser_o && !m_axis_tdata_o[12]), "ack request mismatch")

endmodule

bind cec_bit_timing_receiver_unit cbtr_checker u_cbtr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .pready          (pready)
);
